>>> rtl/stp_pkg.sv
// ============================================================================
// stp_pkg
// Types, constants and microcode ROM for the stepper ramp step generator.
// ============================================================================
package stp_pkg;

  localparam int POS_W       = 32;   // position register width (16..64)
  localparam int PERIOD_FRAC = 8;    // fraction bits of a period
  localparam int PERIOD_W    = 32;
  localparam int ACCEL_W     = 48;
  localparam int DECEL_CFG_W = 31;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 48;
  localparam int MUL_W       = 32;
  localparam int ACC_W       = 3 * PERIOD_W + ACCEL_W;       // p^3 * a
  localparam int OPND_W      = 3 * PERIOD_W;                 // holds p^2, then p^3
  localparam int DELTA_SHIFT = ACCEL_W + 2 * PERIOD_FRAC;    // back to period format
  localparam int DELTA_W     = 64;
  localparam int UPC_W       = 5;

  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [POS_W-2:0]       decel_t;
  typedef logic [PERIOD_W-1:0]    period_t;
  typedef logic [UPC_W-1:0]       upc_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_RAMP_START = cfg_idx_t'(0);
  localparam cfg_idx_t REG_CRUISE     = cfg_idx_t'(1);
  localparam cfg_idx_t REG_ACCEL      = cfg_idx_t'(2);
  localparam cfg_idx_t REG_FULL_DECEL = cfg_idx_t'(3);

  localparam period_t                RST_RAMP_START = period_t'(5724334);
  localparam period_t                RST_CRUISE     = period_t'(256000);
  localparam logic [ACCEL_W-1:0]     RST_ACCEL      = ACCEL_W'(281475);
  localparam logic [DECEL_CFG_W-1:0] RST_FULL_DECEL = DECEL_CFG_W'(500);

  typedef struct packed {
    logic                   kind;
    logic signed [31:0]     target_position;
  } in_t;

  typedef struct packed {
    logic                   step_pulse;
    logic                   moving_down;
    logic signed [31:0]     position;
    logic                   move_done;
    logic [31:0]            active_period;
  } out_t;

  typedef struct packed {
    period_t                  ramp_start_period;
    period_t                  cruise_period;
    logic [ACCEL_W-1:0]       accel_per_us_squared;
    logic [DECEL_CFG_W-1:0]   full_decel_steps;
  } cfg_t;

  typedef enum logic [2:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_BR_NOSTEP,
    SEQ_EMIT,
    SEQ_JUMP
  } seq_op_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_DECODE,
    DP_CAPTURE,
    DP_DELTA,
    DP_NEWP
  } dp_op_t;

  typedef enum logic [1:0] {
    ASEL_P,
    ASEL_O0,
    ASEL_O1,
    ASEL_O2
  } a_sel_t;

  typedef enum logic [1:0] {
    BSEL_P,
    BSEL_A0,
    BSEL_A1
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    seq_op_t      seq;
    upc_t         target;
    dp_op_t       dp;
    a_sel_t       a_sel;
    b_sel_t       b_sel;
    acc_op_t      acc;
    logic [1:0]   acc_sh;   // partial product offset in 32-bit limbs
  } ctrl_t;

  typedef struct packed {
    logic step_hit;
  } status_t;

  typedef struct packed {
    logic         step;
    logic         down;
    logic [31:0]  position;
    logic         done;
    period_t      last_period;
  } result_t;

  localparam upc_t UPC_FETCH  = upc_t'(0);
  localparam upc_t UPC_DECODE = upc_t'(1);
  localparam upc_t UPC_EMIT   = upc_t'(18);

  // Microcode: a word's accumulate step consumes the product started by
  // the word before it.
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t w;
    w = '{SEQ_JUMP, UPC_FETCH, DP_NONE, ASEL_P, BSEL_P, ACC_HOLD, 2'd0};
    case (pc)
      upc_t'(0):  w = '{SEQ_WAIT_IN,   UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      upc_t'(1):  w = '{SEQ_BR_NOSTEP, UPC_EMIT,  DP_DECODE,  ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      // p^2
      upc_t'(2):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      upc_t'(3):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_LOAD, 2'd0};
      upc_t'(4):  w = '{SEQ_NEXT,      UPC_FETCH, DP_CAPTURE, ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      // p^3
      upc_t'(5):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O0, BSEL_P,  ACC_HOLD, 2'd0};
      upc_t'(6):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O1, BSEL_P,  ACC_LOAD, 2'd0};
      upc_t'(7):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_ADD,  2'd1};
      upc_t'(8):  w = '{SEQ_NEXT,      UPC_FETCH, DP_CAPTURE, ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      // a * p^3
      upc_t'(9):  w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O0, BSEL_A0, ACC_HOLD, 2'd0};
      upc_t'(10): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O0, BSEL_A1, ACC_LOAD, 2'd0};
      upc_t'(11): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O1, BSEL_A0, ACC_ADD,  2'd1};
      upc_t'(12): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O1, BSEL_A1, ACC_ADD,  2'd1};
      upc_t'(13): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O2, BSEL_A0, ACC_ADD,  2'd2};
      upc_t'(14): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_O2, BSEL_A1, ACC_ADD,  2'd2};
      upc_t'(15): w = '{SEQ_NEXT,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_ADD,  2'd3};
      upc_t'(16): w = '{SEQ_NEXT,      UPC_FETCH, DP_DELTA,   ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      upc_t'(17): w = '{SEQ_NEXT,      UPC_FETCH, DP_NEWP,    ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      upc_t'(18): w = '{SEQ_EMIT,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
      default:    w = '{SEQ_JUMP,      UPC_FETCH, DP_NONE,    ASEL_P,  BSEL_P,  ACC_HOLD, 2'd0};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/stp_sequencer.sv
// ============================================================================
// stp_sequencer
// Microprogram counter and control ROM with conditional branch on step.
// ============================================================================
module stp_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_free,
  input  stp_pkg::status_t  status,
  output stp_pkg::ctrl_t    ctrl
);

  stp_pkg::upc_t upc;
  stp_pkg::upc_t upc_next;

  assign ctrl = stp_pkg::ucode(upc);

  always_comb begin
    upc_next = upc + stp_pkg::upc_t'(1);
    case (ctrl.seq)
      stp_pkg::SEQ_NEXT:      upc_next = upc + stp_pkg::upc_t'(1);
      stp_pkg::SEQ_WAIT_IN:   upc_next = in_fire ? upc + stp_pkg::upc_t'(1) : upc;
      stp_pkg::SEQ_BR_NOSTEP: upc_next = status.step_hit ? upc + stp_pkg::upc_t'(1) : ctrl.target;
      stp_pkg::SEQ_EMIT:      upc_next = out_free ? ctrl.target : upc;
      stp_pkg::SEQ_JUMP:      upc_next = ctrl.target;
      default:                upc_next = stp_pkg::UPC_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= stp_pkg::UPC_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

>>> rtl/stp_datapath.sv
// ============================================================================
// stp_datapath
// Move state, shared 32x32 multiplier, accumulator and period update.
// ============================================================================
module stp_datapath (
  input  logic              clk,
  input  logic              rst,
  input  stp_pkg::ctrl_t    ctrl,
  input  stp_pkg::cfg_t     cfg,
  input  stp_pkg::in_t      item,
  output stp_pkg::status_t  status,
  output stp_pkg::result_t  result
);

  localparam int ACC_W = stp_pkg::ACC_W;

  // move state
  stp_pkg::pos_t     current_position;
  stp_pkg::pos_t     goal_position;
  stp_pkg::period_t  next_period;
  stp_pkg::decel_t   decel_point;
  logic              decelerating;
  logic              direction_down;
  logic [31:0]       elapsed_ticks;
  stp_pkg::period_t  last_period;
  logic              step_flag;

  // arithmetic
  logic [2*stp_pkg::MUL_W-1:0]  prod;
  logic [ACC_W-1:0]             acc;
  logic [stp_pkg::OPND_W-1:0]   opnd;
  logic [stp_pkg::DELTA_W-1:0]  delta;

  logic [stp_pkg::MUL_W-1:0]    mul_a;
  logic [stp_pkg::MUL_W-1:0]    mul_b;
  logic [ACC_W-1:0]             acc_base;
  logic [ACC_W-1:0]             acc_next;

  // decode
  stp_pkg::pos_t     goal_new;
  logic              down_new;
  stp_pkg::pos_t     dist_new;
  stp_pkg::pos_t     half_new;
  stp_pkg::decel_t   decel_new;
  stp_pkg::pos_t     travel;
  logic [31:0]       elapsed_inc;
  logic              moving;
  logic              hit;

  // delta and new period
  logic [ACC_W:0]               rnd_full;
  logic [ACC_W:0]               rnd_shift;
  logic [stp_pkg::DELTA_W-1:0]  delta_next;
  logic [stp_pkg::PERIOD_W:0]   up_sum;
  stp_pkg::period_t             np_raw;
  stp_pkg::period_t             np;

  always_comb begin
    case (ctrl.a_sel)
      stp_pkg::ASEL_P:  mul_a = next_period;
      stp_pkg::ASEL_O0: mul_a = opnd[31:0];
      stp_pkg::ASEL_O1: mul_a = opnd[63:32];
      stp_pkg::ASEL_O2: mul_a = opnd[95:64];
      default:          mul_a = next_period;
    endcase
    case (ctrl.b_sel)
      stp_pkg::BSEL_P:  mul_b = next_period;
      stp_pkg::BSEL_A0: mul_b = cfg.accel_per_us_squared[31:0];
      stp_pkg::BSEL_A1: mul_b = 32'(cfg.accel_per_us_squared[stp_pkg::ACCEL_W-1:32]);
      default:          mul_b = next_period;
    endcase
  end

  assign acc_base = (ctrl.acc == stp_pkg::ACC_LOAD) ? '0 : acc;
  assign acc_next = acc_base + (ACC_W'(prod) << {ctrl.acc_sh, 5'd0});

  // start of a move
  assign goal_new  = stp_pkg::pos_t'(item.target_position);
  assign down_new  = $signed(goal_new) < $signed(current_position);
  assign dist_new  = down_new ? current_position - goal_new : goal_new - current_position;
  assign half_new  = dist_new >> 1;
  assign decel_new = (64'(half_new) < 64'(cfg.full_decel_steps)) ?
                     stp_pkg::decel_t'(half_new) : stp_pkg::decel_t'(cfg.full_decel_steps);

  // tick
  assign travel      = direction_down ? current_position - goal_position
                                      : goal_position - current_position;
  assign moving      = current_position != goal_position;
  assign elapsed_inc = (elapsed_ticks == '1) ? elapsed_ticks : elapsed_ticks + 32'd1;
  assign hit         = elapsed_inc >= (next_period >> stp_pkg::PERIOD_FRAC);

  assign status.step_hit = !item.kind && moving && hit;

  // round half up, then saturate to the delta width
  assign rnd_full   = {1'b0, acc} + ((ACC_W + 1)'(1) << (stp_pkg::DELTA_SHIFT - 1));
  assign rnd_shift  = rnd_full >> stp_pkg::DELTA_SHIFT;
  assign delta_next = ((rnd_shift >> stp_pkg::DELTA_W) != '0) ? '1
                                                              : rnd_shift[stp_pkg::DELTA_W-1:0];

  assign up_sum = {1'b0, next_period} + (stp_pkg::PERIOD_W + 1)'(delta);

  always_comb begin
    if (decelerating) begin
      np_raw = (delta > stp_pkg::DELTA_W'({stp_pkg::PERIOD_W{1'b1}})
                || up_sum[stp_pkg::PERIOD_W]) ? '1 : up_sum[stp_pkg::PERIOD_W-1:0];
    end else begin
      np_raw = (delta >= stp_pkg::DELTA_W'(next_period)) ? '0
               : next_period - stp_pkg::period_t'(delta);
    end
    np = (np_raw < cfg.cruise_period) ? cfg.cruise_period : np_raw;
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctrl.acc != stp_pkg::ACC_HOLD) begin
      acc <= acc_next;
    end
    if (ctrl.dp == stp_pkg::DP_CAPTURE) begin
      opnd <= acc[stp_pkg::OPND_W-1:0];
    end
    if (ctrl.dp == stp_pkg::DP_DELTA) begin
      delta <= delta_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= '0;
      goal_position    <= '0;
      next_period      <= '0;
      decel_point      <= '0;
      decelerating     <= 1'b0;
      direction_down   <= 1'b0;
      elapsed_ticks    <= '0;
      last_period      <= '0;
      step_flag        <= 1'b0;
    end else begin
      case (ctrl.dp)
        stp_pkg::DP_DECODE: begin
          step_flag <= status.step_hit;
          if (item.kind) begin
            goal_position  <= goal_new;
            direction_down <= down_new;
            decel_point    <= decel_new;
            next_period    <= cfg.ramp_start_period;
            decelerating   <= 1'b0;
            elapsed_ticks  <= '0;
          end else if (moving) begin
            elapsed_ticks <= hit ? '0 : elapsed_inc;
            if (hit) begin
              // flip the ramp at the deceleration point
              if (travel == stp_pkg::pos_t'(decel_point)) begin
                decelerating <= !decelerating;
              end
              current_position <= direction_down ? current_position - stp_pkg::pos_t'(1)
                                                 : current_position + stp_pkg::pos_t'(1);
              last_period <= (travel == stp_pkg::pos_t'(1)) ? '0 : next_period;
            end
          end
        end
        stp_pkg::DP_NEWP: begin
          next_period <= np;
        end
        default: begin
        end
      endcase
    end
  end

  assign result.step        = step_flag;
  assign result.down        = direction_down;
  assign result.position    = 32'(current_position);
  assign result.done        = !moving;
  assign result.last_period = last_period;

endmodule

>>> rtl/stepper_ramp_step_generator.sv
// ============================================================================
// stepper_ramp_step_generator
// Trapezoidal ramp step generator: one result per tick or start transaction.
// ============================================================================
//
//   channel  direction  payload                               handshake
//   in       input      in_data  (kind, target_position)      in_valid/in_ready
//   out      output     out_data (step, dir, pos, done, per)  out_valid/out_ready
//   cfg      input      cfg_index, cfg_data                   cfg_valid/cfg_ready
//
// A start, or a tick that issues no step, goes straight to the emit step; a
// tick that issues a step first computes a*p^3, whose six partial products
// run through the one shared 32x32 multiplier under microcode.
// Synchronous reset loads the register defaults and clears the move state.
// A finished result waits in the output register; the next transaction is
// taken meanwhile and holds at its emit step until the output frees up.
module stepper_ramp_step_generator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  stp_pkg::in_t                        in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output stp_pkg::out_t                       out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  stp_pkg::cfg_idx_t                   cfg_index,
  input  logic [stp_pkg::CFG_DATA_W-1:0]      cfg_data
);

  stp_pkg::cfg_t     cfg;
  stp_pkg::in_t      item;
  stp_pkg::ctrl_t    ctrl;
  stp_pkg::status_t  status;
  stp_pkg::result_t  result;
  logic              in_fire;
  logic              out_free;
  logic              emit;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctrl.seq == stp_pkg::SEQ_WAIT_IN;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign emit      = (ctrl.seq == stp_pkg::SEQ_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_start_period    <= stp_pkg::RST_RAMP_START;
      cfg.cruise_period        <= stp_pkg::RST_CRUISE;
      cfg.accel_per_us_squared <= stp_pkg::RST_ACCEL;
      cfg.full_decel_steps     <= stp_pkg::RST_FULL_DECEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        stp_pkg::REG_RAMP_START: cfg.ramp_start_period    <= cfg_data[31:0];
        stp_pkg::REG_CRUISE:     cfg.cruise_period        <= cfg_data[31:0];
        stp_pkg::REG_ACCEL:      cfg.accel_per_us_squared <= cfg_data[stp_pkg::ACCEL_W-1:0];
        stp_pkg::REG_FULL_DECEL: cfg.full_decel_steps <= cfg_data[stp_pkg::DECEL_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // hold the accepted transaction for the program
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data.step_pulse    <= result.step;
      out_data.moving_down   <= result.down;
      out_data.position      <= result.position;
      out_data.move_done     <= result.done;
      out_data.active_period <= result.done ? '0 : result.last_period;
    end
  end

  stp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .ctrl     (ctrl)
  );

  stp_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .cfg    (cfg),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule
